[rtl/core/smx_pkg.sv]
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants and types for the stack machine executor: field widths,
// defaults, opcodes, error codes and the divider request.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int WORD_W            = 32;
    localparam int PC_W              = 16;
    localparam int OP_W              = 6;
    localparam int ERR_W             = 4;
    localparam int DEF_STORE_DEPTH   = 1024;
    localparam logic [PC_W-1:0] DEF_PROGRAM_LENGTH = 16'hFFFF;

    localparam logic [OP_W-1:0] OP_PUSH   = 6'd0;
    localparam logic [OP_W-1:0] OP_POP    = 6'd1;
    localparam logic [OP_W-1:0] OP_DUP    = 6'd2;
    localparam logic [OP_W-1:0] OP_SWAP   = 6'd3;
    localparam logic [OP_W-1:0] OP_ADD    = 6'd4;
    localparam logic [OP_W-1:0] OP_SUB    = 6'd5;
    localparam logic [OP_W-1:0] OP_MULT   = 6'd6;
    localparam logic [OP_W-1:0] OP_DIV    = 6'd7;
    localparam logic [OP_W-1:0] OP_GOTO   = 6'd8;
    localparam logic [OP_W-1:0] OP_EQ     = 6'd9;
    localparam logic [OP_W-1:0] OP_GT     = 6'd10;
    localparam logic [OP_W-1:0] OP_GE     = 6'd11;
    localparam logic [OP_W-1:0] OP_LT     = 6'd12;
    localparam logic [OP_W-1:0] OP_LE     = 6'd13;
    localparam logic [OP_W-1:0] OP_SKIP   = 6'd14;
    localparam logic [OP_W-1:0] OP_STORE  = 6'd15;
    localparam logic [OP_W-1:0] OP_LOAD   = 6'd16;
    localparam logic [OP_W-1:0] OP_PRINT  = 6'd17;
    localparam logic [OP_W-1:0] OP_JMPZ   = 6'd18;
    localparam logic [OP_W-1:0] OP_JMPN   = 6'd19;
    localparam logic [OP_W-1:0] OP_AND    = 6'd20;
    localparam logic [OP_W-1:0] OP_OR     = 6'd21;
    localparam logic [OP_W-1:0] OP_NEG    = 6'd22;
    localparam logic [OP_W-1:0] OP_NOT    = 6'd23;
    localparam logic [OP_W-1:0] OP_HALT   = 6'd24;
    localparam logic [OP_W-1:0] OP_CALL   = 6'd25;
    localparam logic [OP_W-1:0] OP_MARK   = 6'd26;
    localparam logic [OP_W-1:0] OP_STORER = 6'd27;
    localparam logic [OP_W-1:0] OP_LOADR  = 6'd28;
    localparam logic [OP_W-1:0] OP_PUSHA  = 6'd29;
    localparam logic [OP_W-1:0] OP_ENTER  = 6'd30;
    localparam logic [OP_W-1:0] OP_ALLOC  = 6'd31;
    localparam logic [OP_W-1:0] OP_RETURN = 6'd32;
    localparam logic [OP_W-1:0] OP_LOADA  = 6'd33;

    localparam logic [ERR_W-1:0] ERR_NONE      = 4'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY     = 4'd1;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 4'd2;
    localparam logic [ERR_W-1:0] ERR_ABOVE_TOP = 4'd3;
    localparam logic [ERR_W-1:0] ERR_NONPOS    = 4'd4;
    localparam logic [ERR_W-1:0] ERR_FRAME     = 4'd5;
    localparam logic [ERR_W-1:0] ERR_FULL      = 4'd6;
    localparam logic [ERR_W-1:0] ERR_DIV0      = 4'd7;
    localparam logic [ERR_W-1:0] ERR_PC_RANGE  = 4'd8;

    typedef struct packed {
        logic                    start;
        logic signed [WORD_W-1:0] dividend;
        logic signed [WORD_W-1:0] divisor;
    } t_div_req;

endpackage

[rtl/core/smx_ram.sv]
// ----------------------------------------------------------------------------
// smx_ram
// Single-port word store; read data is registered and appears in the cycle after the read.
// ----------------------------------------------------------------------------
module smx_ram
    import smx_pkg::*;
#(
    parameter int DEPTH = DEF_STORE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [AW-1:0]     i_addr,
    input  logic [WORD_W-1:0] i_wdata,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/smx_div.sv]
// ----------------------------------------------------------------------------
// smx_div
// Iterative signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module smx_div
    import smx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [WORD_W-1:0] o_quotient
);

    localparam int CW = $clog2(WORD_W);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [CW-1:0]     r_cnt;
    logic [WORD_W:0]   r_rem;
    logic [WORD_W-1:0] r_q;
    logic [WORD_W-1:0] r_d;
    logic [WORD_W:0]   n_shift;
    logic [WORD_W:0]   n_diff;

    assign n_shift = {r_rem[WORD_W-1:0], r_q[WORD_W-1]};
    assign n_diff  = n_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(WORD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_neg <= i_req.dividend[WORD_W-1] ^ i_req.divisor[WORD_W-1];
            r_q   <= i_req.dividend[WORD_W-1] ? (-i_req.dividend) : i_req.dividend;
            r_d   <= i_req.divisor[WORD_W-1] ? (-i_req.divisor) : i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (!n_diff[WORD_W]) begin
                r_rem <= n_diff;
                r_q   <= {r_q[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_q   <= {r_q[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (-r_q) : r_q;

endmodule

[rtl/core/stack_machine_executor_unit.sv]
// Each instruction runs through accept, up to three store reads, execute, up to
// two store writes and result; divide waits for the iterative divider between
// execute and the writes. One instruction is in work at a time; the single store
// port sets the rate. After reset a clearing pass writes zero to every entry,
// during which no request is accepted.
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// Stack machine executor: runs one instruction per request against a word
// store holding the operand stack and the procedure frames.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit
    import smx_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PC_W-1:0]   i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [WORD_W-1:0] i_argument,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PC_W-1:0]   o_next_pc,
    output logic              o_print_valid,
    output logic [WORD_W-1:0] o_print_value,
    output logic              o_halted,
    output logic [ERR_W-1:0]  o_error_code
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int XW = 34;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic signed [XW-1:0] DEPTH_X = XW'(STORE_DEPTH);

    logic [2:0]        r_state;
    logic [AW-1:0]     r_clr;
    logic [PC_W-1:0]   r_plen;
    logic [AW-1:0]     r_sp;
    logic [AW-1:0]     r_fp;
    logic [AW-1:0]     r_ep;
    logic [PC_W-1:0]   r_pc;
    logic              r_stopped;
    logic [ERR_W-1:0]  r_lerr;
    logic [OP_W-1:0]   r_op;
    logic [WORD_W-1:0] r_arg;
    logic [AW-1:0]     r_ra0;
    logic [AW-1:0]     r_ra1;
    logic [AW-1:0]     r_ra2;
    logic [1:0]        r_nr;
    logic [1:0]        r_rk;
    logic [WORD_W-1:0] r_w0;
    logic [WORD_W-1:0] r_w1;
    logic [WORD_W-1:0] r_w2;
    logic [1:0]        r_nwr;
    logic              r_wk;
    logic [AW-1:0]     r_wa0;
    logic [AW-1:0]     r_wa1;
    logic [WORD_W-1:0] r_wd0;
    logic [WORD_W-1:0] r_wd1;
    logic              r_pv;
    logic [WORD_W-1:0] r_pval;
    logic              r_ovalid;
    logic [PC_W-1:0]   r_onpc;
    logic              r_opv;
    logic [WORD_W-1:0] r_opval;
    logic              r_ohalt;
    logic [ERR_W-1:0]  r_oerr;

    logic [AW-1:0]     n_ra0;
    logic [AW-1:0]     n_ra1;
    logic [AW-1:0]     n_ra2;
    logic [1:0]        n_nr;
    logic signed [XW-1:0] n_laddr;

    logic              m_en;
    logic              m_we;
    logic [AW-1:0]     m_addr;
    logic [WORD_W-1:0] m_wdata;
    logic [WORD_W-1:0] m_rdata;

    t_div_req          d_req;
    logic              d_done;
    logic [WORD_W-1:0] d_quot;

    logic signed [XW-1:0] s_sp;
    logic signed [XW-1:0] s_fp;
    logic signed [XW-1:0] s_arg;
    logic signed [XW-1:0] s_pc;
    logic signed [XW-1:0] s_plen;
    logic signed [XW-1:0] s_addr;
    logic signed [XW-1:0] s_r;
    logic signed [XW-1:0] s_a;
    logic signed [XW-1:0] s_b;
    logic signed [XW-1:0] c_nxt;
    logic [ERR_W-1:0]  c_err;
    logic              c_halt;
    logic              c_div;
    logic [AW-1:0]     c_nsp;
    logic [AW-1:0]     c_nfp;
    logic [AW-1:0]     c_nep;
    logic [1:0]        c_nwr;
    logic [AW-1:0]     c_wa0;
    logic [AW-1:0]     c_wa1;
    logic [WORD_W-1:0] c_wd0;
    logic [WORD_W-1:0] c_wd1;
    logic              c_pv;
    logic              c_take;

    smx_ram #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (m_en),
        .i_we    (m_we),
        .i_addr  (m_addr),
        .i_wdata (m_wdata),
        .o_rdata (m_rdata)
    );

    smx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (d_req),
        .o_done     (d_done),
        .o_quotient (d_quot)
    );

    // Read plan for the incoming instruction.
    always_comb begin
        n_ra0   = r_sp;
        n_ra1   = r_sp - 1'b1;
        n_ra2   = r_fp - 1'b1;
        n_nr    = 2'd0;
        n_laddr = (i_opcode == OP_LOAD) ? XW'($signed(i_argument))
                : XW'($signed({1'b0, r_fp})) + XW'($signed(i_argument));
        case (i_opcode)
            OP_DUP, OP_PRINT, OP_JMPZ, OP_JMPN, OP_NEG, OP_NOT, OP_CALL,
            OP_STORE, OP_STORER: begin
                n_nr = 2'd1;
            end
            OP_SWAP, OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_EQ, OP_GT, OP_GE,
            OP_LT, OP_LE, OP_AND, OP_OR: begin
                n_nr = 2'd2;
            end
            OP_LOAD, OP_LOADR, OP_LOADA: begin
                n_ra0 = n_laddr[AW-1:0];
                if (n_laddr > 0 && n_laddr <= XW'($signed({1'b0, r_sp}))) begin
                    n_nr = 2'd1;
                end
            end
            OP_RETURN: begin
                n_ra0 = r_fp;
                n_ra1 = r_fp - 2'd2;
                n_nr  = 2'd3;
            end
            default: begin
                n_nr = 2'd0;
            end
        endcase
    end

    // Execute step.
    always_comb begin
        s_sp   = XW'($signed({1'b0, r_sp}));
        s_fp   = XW'($signed({1'b0, r_fp}));
        s_arg  = XW'($signed(r_arg));
        s_pc   = XW'($signed({1'b0, r_pc}));
        s_plen = XW'($signed({1'b0, r_plen}));
        s_addr = (r_op == OP_STORE || r_op == OP_LOAD) ? s_arg : s_fp + s_arg;
        s_r    = s_sp + s_arg;
        s_a    = XW'($signed(r_w1));
        s_b    = XW'($signed(r_w2));
        c_nxt  = s_pc + 1'b1;
        c_err  = ERR_NONE;
        c_halt = 1'b0;
        c_div  = 1'b0;
        c_nsp  = r_sp;
        c_nfp  = r_fp;
        c_nep  = r_ep;
        c_nwr  = 2'd0;
        c_wa0  = r_sp - 1'b1;
        c_wa1  = r_sp;
        c_wd0  = '0;
        c_wd1  = '0;
        c_pv   = 1'b0;
        c_take = 1'b0;
        case (r_op)
            OP_PUSH, OP_PUSHA: begin
                if (s_sp + 1 >= DEPTH_X) begin
                    c_err = ERR_FULL;
                end else begin
                    c_nsp = r_sp + 1'b1;
                    c_wa0 = r_sp + 1'b1;
                    c_wd0 = r_arg;
                    c_nwr = 2'd1;
                end
            end
            OP_POP: begin
                if (r_sp == '0) begin
                    c_err = ERR_EMPTY;
                end else begin
                    c_nsp = r_sp - 1'b1;
                end
            end
            OP_DUP: begin
                if (r_sp == '0) begin
                    c_err = ERR_EMPTY;
                end else if (s_sp + 1 >= DEPTH_X) begin
                    c_err = ERR_FULL;
                end else begin
                    c_nsp = r_sp + 1'b1;
                    c_wa0 = r_sp + 1'b1;
                    c_wd0 = r_w0;
                    c_nwr = 2'd1;
                end
            end
            OP_SWAP, OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_EQ, OP_GT, OP_GE,
            OP_LT, OP_LE, OP_AND, OP_OR: begin
                if (s_sp < 2) begin
                    c_err = ERR_UNDERFLOW;
                end else if (r_op == OP_SWAP) begin
                    c_wd0 = r_w0;
                    c_wd1 = r_w1;
                    c_nwr = 2'd2;
                end else begin
                    c_nsp = r_sp - 1'b1;
                    c_nwr = 2'd1;
                    case (r_op)
                        OP_ADD:  c_wd0 = r_w1 + r_w0;
                        OP_SUB:  c_wd0 = r_w1 - r_w0;
                        OP_MULT: c_wd0 = r_w1 * r_w0;
                        OP_DIV: begin
                            if (r_w0 == '0) begin
                                c_err = ERR_DIV0;
                            end else begin
                                c_div = 1'b1;
                            end
                        end
                        OP_EQ:   c_wd0 = WORD_W'(r_w1 == r_w0);
                        OP_GT:   c_wd0 = WORD_W'($signed(r_w1) > $signed(r_w0));
                        OP_GE:   c_wd0 = WORD_W'($signed(r_w1) >= $signed(r_w0));
                        OP_LT:   c_wd0 = WORD_W'($signed(r_w1) < $signed(r_w0));
                        OP_LE:   c_wd0 = WORD_W'($signed(r_w1) <= $signed(r_w0));
                        OP_AND:  c_wd0 = WORD_W'(r_w1 != '0 && r_w0 != '0);
                        OP_OR:   c_wd0 = WORD_W'(r_w1 != '0 || r_w0 != '0);
                        default: c_wd0 = '0;
                    endcase
                end
            end
            OP_GOTO: begin
                c_nxt = s_arg;
            end
            OP_SKIP: begin
                c_nxt = s_pc + 1'b1;
            end
            OP_STORE, OP_STORER: begin
                if (r_sp == '0) begin
                    c_err = ERR_EMPTY;
                end else if (s_addr > s_sp) begin
                    c_err = ERR_ABOVE_TOP;
                end else if (s_addr <= 0) begin
                    c_err = ERR_NONPOS;
                end else begin
                    c_wa0 = s_addr[AW-1:0];
                    c_wd0 = r_w0;
                    c_nwr = 2'd1;
                    c_nsp = r_sp - 1'b1;
                end
            end
            OP_LOAD, OP_LOADR, OP_LOADA: begin
                if (s_addr > s_sp) begin
                    c_err = ERR_ABOVE_TOP;
                end else if (s_addr <= 0) begin
                    c_err = ERR_NONPOS;
                end else if (s_sp + 1 >= DEPTH_X) begin
                    c_err = ERR_FULL;
                end else begin
                    c_wa0 = r_sp + 1'b1;
                    c_wd0 = r_w0;
                    c_nwr = 2'd1;
                    c_nsp = r_sp + 1'b1;
                end
            end
            OP_PRINT: begin
                if (r_sp == '0) begin
                    c_err = ERR_UNDERFLOW;
                end else begin
                    c_pv  = 1'b1;
                    c_nsp = r_sp - 1'b1;
                end
            end
            OP_JMPZ, OP_JMPN: begin
                if (r_sp == '0) begin
                    c_err = ERR_UNDERFLOW;
                end else begin
                    c_take = (r_w0 == '0) ? (r_op == OP_JMPZ) : (r_op == OP_JMPN);
                    c_nsp  = r_sp - 1'b1;
                    if (c_take) begin
                        c_nxt = s_arg;
                    end
                end
            end
            OP_NEG, OP_NOT: begin
                if (r_sp == '0) begin
                    c_err = ERR_UNDERFLOW;
                end else begin
                    c_wa0 = r_sp;
                    c_wd0 = (r_op == OP_NEG) ? (-r_w0) : WORD_W'(r_w0 == '0);
                    c_nwr = 2'd1;
                end
            end
            OP_CALL: begin
                c_nfp = r_sp;
                c_nxt = XW'($signed(r_w0)) + 1'b1;
                c_wa0 = r_sp;
                c_wd0 = WORD_W'(r_pc);
                c_nwr = 2'd1;
            end
            OP_MARK: begin
                if (s_sp + 2 >= DEPTH_X) begin
                    c_err = ERR_FULL;
                end else begin
                    c_wa0 = r_sp + 1'b1;
                    c_wd0 = WORD_W'(r_ep);
                    c_wa1 = r_sp + 2'd2;
                    c_wd1 = WORD_W'(r_fp);
                    c_nwr = 2'd2;
                    c_nsp = r_sp + 2'd2;
                end
            end
            OP_ENTER: begin
                if (s_r < 0 || s_r >= DEPTH_X) begin
                    c_err = ERR_FRAME;
                end else begin
                    c_nep = s_r[AW-1:0];
                end
            end
            OP_ALLOC: begin
                if (s_r < 0) begin
                    c_err = ERR_UNDERFLOW;
                end else if (s_r >= DEPTH_X) begin
                    c_err = ERR_FULL;
                end else begin
                    c_nsp = s_r[AW-1:0];
                end
            end
            OP_RETURN: begin
                s_r   = s_fp - s_arg;
                c_nxt = XW'($signed(r_w0)) + 1'b1;
                if (s_fp < 2) begin
                    c_err = ERR_UNDERFLOW;
                end else if (s_a < 0 || s_a >= DEPTH_X) begin
                    c_err = ERR_FRAME;
                end else if (s_r < 0) begin
                    c_err = ERR_UNDERFLOW;
                end else if (s_r >= DEPTH_X) begin
                    c_err = ERR_FULL;
                end else if (s_b < 0 || s_b >= DEPTH_X) begin
                    c_err = ERR_FRAME;
                end else begin
                    c_nep = s_a[AW-1:0];
                    c_nsp = s_r[AW-1:0];
                    c_nfp = s_b[AW-1:0];
                end
            end
            default: begin
                c_halt = 1'b1;
            end
        endcase
        if (s_pc >= s_plen) begin
            c_err  = ERR_PC_RANGE;
            c_halt = 1'b0;
        end else if (c_err == ERR_NONE && !c_halt && (c_nxt < 0 || c_nxt >= s_plen)) begin
            c_err = ERR_PC_RANGE;
        end
        if (c_err != ERR_NONE || c_halt) begin
            c_div = 1'b0;
        end
    end

    always_comb begin
        d_req.start    = (r_state == S_CALC) && !r_stopped && c_div;
        d_req.dividend = $signed(r_w1);
        d_req.divisor  = $signed(r_w0);
    end

    always_comb begin
        m_en    = 1'b0;
        m_we    = 1'b0;
        m_addr  = r_ra0;
        m_wdata = '0;
        case (r_state)
            S_CLR: begin
                m_en   = 1'b1;
                m_we   = 1'b1;
                m_addr = r_clr;
            end
            S_RD: begin
                m_en   = (r_rk < r_nr);
                m_addr = (r_rk == 2'd0) ? r_ra0 : (r_rk == 2'd1) ? r_ra1 : r_ra2;
            end
            S_WR: begin
                m_en    = 1'b1;
                m_we    = 1'b1;
                m_addr  = r_wk ? r_wa1 : r_wa0;
                m_wdata = r_wk ? r_wd1 : r_wd0;
            end
            default: begin
                m_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_plen    <= DEF_PROGRAM_LENGTH;
            r_sp      <= '0;
            r_fp      <= '0;
            r_ep      <= AW'(STORE_DEPTH - 1);
            r_pc      <= '0;
            r_stopped <= 1'b0;
            r_lerr    <= ERR_NONE;
            r_ovalid  <= 1'b0;
            r_rk      <= '0;
            r_wk      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_plen <= i_cfg_data;
            end
            if (r_state == S_FIN && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(STORE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_rk <= '0;
                    if (i_in_valid) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_rk <= r_rk + 1'b1;
                    if (r_rk == r_nr) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_wk <= 1'b0;
                    if (r_stopped) begin
                        r_state <= S_FIN;
                    end else if (c_err != ERR_NONE || c_halt) begin
                        r_stopped <= 1'b1;
                        r_lerr    <= c_err;
                        r_state   <= S_FIN;
                    end else begin
                        r_sp <= c_nsp;
                        r_fp <= c_nfp;
                        r_ep <= c_nep;
                        r_pc <= c_nxt[PC_W-1:0];
                        if (c_div) begin
                            r_state <= S_DIV;
                        end else if (c_nwr != 2'd0) begin
                            r_state <= S_WR;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    if (d_done) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_wk <= 1'b1;
                    if (r_wk || r_nwr == 2'd1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op  <= i_opcode;
            r_arg <= i_argument;
            r_ra0 <= n_ra0;
            r_ra1 <= n_ra1;
            r_ra2 <= n_ra2;
            r_nr  <= n_nr;
        end
        if (r_state == S_RD) begin
            case (r_rk)
                2'd1:    r_w0 <= m_rdata;
                2'd2:    r_w1 <= m_rdata;
                2'd3:    r_w2 <= m_rdata;
                default: r_w2 <= r_w2;
            endcase
        end
        if (r_state == S_CALC) begin
            r_nwr  <= c_nwr;
            r_wa0  <= c_wa0;
            r_wa1  <= c_wa1;
            r_wd0  <= c_wd0;
            r_wd1  <= c_wd1;
            r_pv   <= c_pv && !r_stopped && c_err == ERR_NONE && !c_halt;
            r_pval <= r_w0;
        end
        if (r_state == S_DIV && d_done) begin
            r_wd0 <= d_quot;
        end
        if (r_state == S_FIN && (!r_ovalid || i_out_ready)) begin
            r_onpc  <= r_pc;
            r_opv   <= r_pv;
            r_opval <= r_pv ? r_pval : '0;
            r_ohalt <= r_stopped;
            r_oerr  <= r_lerr;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_next_pc     = r_onpc;
    assign o_print_valid = r_opv;
    assign o_print_value = r_opval;
    assign o_halted      = r_ohalt;
    assign o_error_code  = r_oerr;

endmodule

[rtl/core/smx_checker.sv]
// ----------------------------------------------------------------------------
// smx_checker
// Port-level checks for the stack machine executor, bound to the top level.
// ----------------------------------------------------------------------------
module smx_checker
    import smx_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_print_valid,
    input logic [WORD_W-1:0] o_print_value,
    input logic              o_halted,
    input logic [ERR_W-1:0]  o_error_code
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result request dropped before it was taken");

    a_no_print_when_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_halted && o_print_valid))
        else $error("print reported on a halted result");

    a_print_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_print_valid |-> o_print_value == '0)
        else $error("print value nonzero without print");

    a_error_implies_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_halted |-> o_error_code == ERR_NONE)
        else $error("error code reported while running");

endmodule

bind stack_machine_executor_unit smx_checker u_smx_checker (.*);

[tb/tb_stack_machine_executor_unit.sv]
// ----------------------------------------------------------------------------
// Stack machine executor unit testbench
// Drives instruction requests into the executor and checks every result
// against a cycle-free predictor of the machine. A directed sequence covers
// arithmetic extremes and every opcode but halt. Random phases follow under
// program lengths of 300, 40 and the default maximum. Random instructions are
// screened against the predictor so that the machine keeps running deep into
// calls, frames and memory traffic. The run ends with one deliberate stop, a
// halt or a fault, and three further requests check that the machine stays stopped.
// ----------------------------------------------------------------------------
module tb_stack_machine_executor_unit;
    import smx_pkg::*;

    localparam int DEPTH      = DEF_STORE_DEPTH;
    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE     = 60;

    typedef struct {
        logic [PC_W-1:0]   next_pc;
        logic              print_valid;
        logic [WORD_W-1:0] print_value;
        logic              halted;
        logic [ERR_W-1:0]  error_code;
    } t_status;

    class executor_scoreboard;
        logic [WORD_W-1:0] mem [DEPTH];
        longint            sp;
        longint            fp;
        longint            ep;
        int unsigned       pc;
        bit                stopped;
        logic [ERR_W-1:0]  last_err;
        int unsigned       length;
        t_status           expected_q[$];
        int                errors;
        int                checked;
        int                prints;

        function new();
            foreach (mem[i]) mem[i] = '0;
            sp = 0;
            fp = 0;
            ep = DEPTH - 1;
            pc = 0;
            stopped = 0;
            last_err = ERR_NONE;
            length = DEF_PROGRAM_LENGTH;
            errors = 0;
            checked = 0;
            prints = 0;
        endfunction

        function logic [WORD_W-1:0] rd(longint i);
            if (i < 0 || i >= DEPTH) return '0;
            return mem[i];
        endfunction

        function longint sg(logic [WORD_W-1:0] w);
            return longint'($signed(w));
        endfunction

        function int addr_fault(longint a);
            if (a > sp) return ERR_ABOVE_TOP;
            if (a <= 0) return ERR_NONPOS;
            return 0;
        endfunction

        // Returns 0 on success, -1 on halt, or an error code. State is only
        // updated when commit is set and the instruction succeeds.
        function int execute(logic [OP_W-1:0] op, logic [WORD_W-1:0] arg, bit commit,
                             output longint npc, output bit pv,
                             output logic [WORD_W-1:0] pval);
            longint nsp, nfp, nep, nxt, a, b, r, addr, argv;
            longint wa[2];
            logic [WORD_W-1:0] wv[2];
            int nw, e;
            nsp = sp; nfp = fp; nep = ep;
            nxt = longint'(pc) + 1;
            argv = sg(arg);
            nw = 0; r = 0; pv = 0; pval = '0; npc = 0;
            case (op)
                OP_PUSH, OP_PUSHA: begin
                    if (nsp + 1 >= DEPTH) return ERR_FULL;
                    nsp++; wa[0] = nsp; wv[0] = arg; nw = 1;
                end
                OP_POP: begin
                    if (nsp == 0) return ERR_EMPTY;
                    nsp--;
                end
                OP_DUP: begin
                    if (nsp == 0) return ERR_EMPTY;
                    if (nsp + 1 >= DEPTH) return ERR_FULL;
                    wa[0] = nsp + 1; wv[0] = rd(nsp); nw = 1; nsp++;
                end
                OP_SWAP, OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_EQ, OP_GT, OP_GE,
                OP_LT, OP_LE, OP_AND, OP_OR: begin
                    if (nsp < 2) return ERR_UNDERFLOW;
                    b = sg(rd(nsp));
                    a = sg(rd(nsp - 1));
                    case (op)
                        OP_ADD:  r = a + b;
                        OP_SUB:  r = a - b;
                        OP_MULT: r = a * b;
                        OP_DIV: begin
                            if (b == 0) return ERR_DIV0;
                            r = a / b;
                        end
                        OP_EQ:   r = (a == b);
                        OP_GT:   r = (a > b);
                        OP_GE:   r = (a >= b);
                        OP_LT:   r = (a < b);
                        OP_LE:   r = (a <= b);
                        OP_AND:  r = (a != 0 && b != 0);
                        OP_OR:   r = (a != 0 || b != 0);
                        default: r = 0;
                    endcase
                    if (op == OP_SWAP) begin
                        wa[0] = nsp - 1; wv[0] = rd(nsp);
                        wa[1] = nsp; wv[1] = rd(nsp - 1); nw = 2;
                    end else begin
                        wa[0] = nsp - 1; wv[0] = r[WORD_W-1:0]; nw = 1; nsp--;
                    end
                end
                OP_GOTO: nxt = argv;
                OP_SKIP: ;
                OP_STORE, OP_STORER: begin
                    if (nsp == 0) return ERR_EMPTY;
                    addr = (op == OP_STORE) ? argv : nfp + argv;
                    e = addr_fault(addr);
                    if (e != 0) return e;
                    wa[0] = addr; wv[0] = rd(nsp); nw = 1; nsp--;
                end
                OP_LOAD, OP_LOADR, OP_LOADA: begin
                    addr = (op == OP_LOAD) ? argv : nfp + argv;
                    e = addr_fault(addr);
                    if (e != 0) return e;
                    if (nsp + 1 >= DEPTH) return ERR_FULL;
                    wa[0] = nsp + 1; wv[0] = rd(addr); nw = 1; nsp++;
                end
                OP_PRINT: begin
                    if (nsp == 0) return ERR_UNDERFLOW;
                    pv = 1; pval = rd(nsp); nsp--;
                end
                OP_JMPZ, OP_JMPN: begin
                    if (nsp == 0) return ERR_UNDERFLOW;
                    r = (rd(nsp) == 0) ? (op == OP_JMPZ) : (op == OP_JMPN);
                    nsp--;
                    if (r != 0) nxt = argv;
                end
                OP_NEG, OP_NOT: begin
                    if (nsp == 0) return ERR_UNDERFLOW;
                    wa[0] = nsp; nw = 1;
                    wv[0] = (op == OP_NEG) ? (32'd0 - rd(nsp)) : {31'd0, rd(nsp) == 0};
                end
                OP_CALL: begin
                    nfp = nsp;
                    nxt = sg(rd(nsp)) + 1;
                    wa[0] = nsp; wv[0] = pc; nw = 1;
                end
                OP_MARK: begin
                    if (nsp + 2 >= DEPTH) return ERR_FULL;
                    wa[0] = nsp + 1; wv[0] = nep[WORD_W-1:0];
                    wa[1] = nsp + 2; wv[1] = nfp[WORD_W-1:0]; nw = 2; nsp += 2;
                end
                OP_ENTER: begin
                    r = nsp + argv;
                    if (r < 0 || r >= DEPTH) return ERR_FRAME;
                    nep = r;
                end
                OP_ALLOC: begin
                    r = nsp + argv;
                    if (r < 0) return ERR_UNDERFLOW;
                    if (r >= DEPTH) return ERR_FULL;
                    nsp = r;
                end
                OP_RETURN: begin
                    if (nfp < 2) return ERR_UNDERFLOW;
                    nxt = sg(rd(nfp)) + 1;
                    a = sg(rd(nfp - 2));
                    if (a < 0 || a >= DEPTH) return ERR_FRAME;
                    r = nfp - argv;
                    if (r < 0) return ERR_UNDERFLOW;
                    if (r >= DEPTH) return ERR_FULL;
                    b = sg(rd(nfp - 1));
                    if (b < 0 || b >= DEPTH) return ERR_FRAME;
                    nep = a; nsp = r; nfp = b;
                end
                default: return -1;
            endcase
            if (nxt < 0 || nxt >= longint'(length)) return ERR_PC_RANGE;
            if (commit) begin
                for (int i = 0; i < nw; i++)
                    if (wa[i] >= 0 && wa[i] < DEPTH) mem[wa[i]] = wv[i];
                sp = nsp; fp = nfp; ep = nep;
            end
            npc = nxt;
            return 0;
        endfunction

        function int would_fault(logic [OP_W-1:0] op, logic [WORD_W-1:0] arg);
            longint npc;
            bit pv;
            logic [WORD_W-1:0] pval;
            if (stopped || pc >= length) return ERR_PC_RANGE;
            return execute(op, arg, 0, npc, pv, pval);
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] arg);
            longint npc;
            bit pv;
            logic [WORD_W-1:0] pval;
            int res;
            t_status s;
            pv = 0;
            pval = '0;
            if (!stopped) begin
                if (pc >= length) res = ERR_PC_RANGE;
                else res = execute(op, arg, 1, npc, pv, pval);
                if (res == 0) begin
                    pc = 32'(npc[PC_W-1:0]);
                end else begin
                    stopped = 1;
                    last_err = (res > 0) ? res[ERR_W-1:0] : ERR_NONE;
                    pv = 0;
                    pval = '0;
                end
            end
            s.next_pc = pc[PC_W-1:0];
            s.print_valid = pv;
            s.print_value = pv ? pval : '0;
            s.halted = stopped;
            s.error_code = last_err;
            if (pv) prints++;
            expected_q.push_back(s);
        endfunction

        function void check_result(t_status got);
            t_status want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request pending, next_pc %0d", $time, got.next_pc);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.next_pc !== want.next_pc) begin
                $display("%0t: next_pc expected %0d actual %0d", $time, want.next_pc, got.next_pc);
                errors++;
            end
            if (got.print_valid !== want.print_valid) begin
                $display("%0t: print_valid expected %0b actual %0b", $time,
                         want.print_valid, got.print_valid);
                errors++;
            end
            if (got.print_value !== want.print_value) begin
                $display("%0t: print_value expected %h actual %h", $time,
                         want.print_value, got.print_value);
                errors++;
            end
            if (got.halted !== want.halted) begin
                $display("%0t: halted expected %0b actual %0b", $time, want.halted, got.halted);
                errors++;
            end
            if (got.error_code !== want.error_code) begin
                $display("%0t: error_code expected %0d actual %0d", $time,
                         want.error_code, got.error_code);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [PC_W-1:0]   i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_opcode = '0;
    logic [WORD_W-1:0] i_argument = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [PC_W-1:0]   o_next_pc;
    logic              o_print_valid;
    logic [WORD_W-1:0] o_print_value;
    logic              o_halted;
    logic [ERR_W-1:0]  o_error_code;

    executor_scoreboard sb = new();
    bit calm = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int requests = 0;
    int sent = 0;

    stack_machine_executor_unit i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_opcode(i_opcode),
        .i_argument(i_argument),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_next_pc(o_next_pc),
        .o_print_valid(o_print_valid),
        .o_print_value(o_print_value),
        .o_halted(o_halted),
        .o_error_code(o_error_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_request(i_opcode, i_argument);
            requests++;
        end
    end

    always @(posedge i_clk) begin
        t_status got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.next_pc = o_next_pc;
            got.print_valid = o_print_valid;
            got.print_value = o_print_value;
            got.halted = o_halted;
            got.error_code = o_error_code;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_out_ready <= 1'b1;
            end else begin
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(20, 60);
                i_out_ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function int gap_length();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // The predictor must have taken the last accepted request before it is asked.
    task automatic sync_sb();
        wait (requests == sent);
    endtask

    task automatic send(logic [OP_W-1:0] op, logic [WORD_W-1:0] arg);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_argument <= arg;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    task automatic send_safe(logic [OP_W-1:0] op, logic [WORD_W-1:0] arg);
        sync_sb();
        if (sb.would_fault(op, arg) != 0) begin
            if (sb.would_fault(OP_SKIP, '0) == 0) send(OP_SKIP, '0);
            else send(OP_GOTO, '0);
        end else begin
            send(op, arg);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        sync_sb();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(logic [PC_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.length = 32'(value);
    endtask

    task automatic random_instr(output logic [OP_W-1:0] op, output logic [WORD_W-1:0] arg);
        int kind;
        op = ($urandom_range(0, 3) == 0) ? OP_PUSH : OP_W'($urandom_range(0, 33));
        if (op == OP_HALT) op = OP_SKIP;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: arg = $urandom_range(0, 15);
            4:          arg = -$urandom_range(1, 4);
            5, 6:       arg = $urandom_range(0, sb.length - 1);
            7, 8:       arg = $urandom;
            default:    arg = $urandom_range(1, (sb.sp > 1) ? int'(sb.sp) : 1);
        endcase
    endtask

    task automatic random_phase(int count);
        logic [OP_W-1:0] op;
        logic [WORD_W-1:0] arg;
        int tries;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
            sync_sb();
            tries = 0;
            do begin
                random_instr(op, arg);
                tries++;
            end while (sb.would_fault(op, arg) != 0 && tries < 30);
            send_safe(op, arg);
        end
        calm = 0;
    endtask

    task automatic directed_phase();
        logic [OP_W-1:0] ops[$];
        logic [WORD_W-1:0] args[$];
        ops = '{OP_PUSH, OP_PUSH, OP_ADD, OP_PUSH, OP_DIV, OP_DUP, OP_MULT,
                OP_PUSH, OP_NEG, OP_NOT, OP_SWAP, OP_SUB, OP_PUSH, OP_GT,
                OP_PUSH, OP_PUSH, OP_GE, OP_PUSH, OP_LT, OP_PUSH, OP_LE,
                OP_PUSH, OP_EQ, OP_PUSH, OP_AND, OP_PUSH, OP_OR, OP_DUP,
                OP_PRINT, OP_STORE, OP_LOAD, OP_PUSH, OP_JMPZ, OP_PUSH,
                OP_JMPN, OP_GOTO, OP_SKIP, OP_POP, OP_MARK, OP_PUSHA, OP_CALL,
                OP_ENTER, OP_ALLOC, OP_LOADR, OP_STORER, OP_LOADA, OP_RETURN,
                OP_PRINT};
        args = '{32'h7FFF_FFFF, 32'd1, 0, 32'hFFFF_FFFF, 0, 0, 0,
                 32'h8000_0000, 0, 0, 0, 0, 32'd3, 0,
                 32'd5, 32'd5, 0, 32'd9, 0, 32'd0, 0,
                 32'h8000_0000, 0, 32'd0, 0, 32'd0, 0, 0,
                 0, 32'd1, 32'd1, 32'd0, 32'd60, 32'd4,
                 32'd70, 32'd80, 0, 0, 0, 32'd100, 0,
                 32'd5, 32'd2, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd3,
                 0};
        foreach (ops[i]) send_safe(ops[i], args[i]);
    endtask

    task automatic final_fault();
        case ($urandom_range(0, 3))
            0: send(OP_HALT, $urandom);
            1: send(6'h3F, $urandom);
            2: begin
                send_safe(OP_PUSH, 32'd9);
                send_safe(OP_PUSH, 32'd0);
                send(OP_DIV, '0);
            end
            default: send(OP_GOTO, sb.length);
        endcase
        repeat (3) send(OP_W'($urandom_range(0, 63)), $urandom);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_phase();
        drain();
        repeat (4) send_safe(OP_GOTO, '0);
        drain();
        write_length(16'd1);
        repeat (5) send(OP_GOTO, '0);
        drain();
        write_length(16'd300);
        random_phase(150);
        send(OP_GOTO, '0);
        drain();
        write_length(16'd40);
        random_phase(150);
        drain();
        write_length(DEF_PROGRAM_LENGTH);
        random_phase(200);
        final_fault();
        drain();
        $display("Ran %0d requests through directed, short and long program phases,",
                 requests);
        $display("%0d results checked, %0d prints, ending on fault code %0d.",
                 sb.checked, sb.prints, sb.last_err);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
